### sv/timestamped_history_ring_defines.svh
// assertion macros for the timestamped history ring
// used by the top level only, expects clk and rst_n in scope
`ifndef TIMESTAMPED_HISTORY_RING_DEFINES_SVH
`define TIMESTAMPED_HISTORY_RING_DEFINES_SVH

// same-cycle implication
`define THR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/thr_pkg.sv
// types and codes shared by the history ring cells and top level
// no dependencies
package thr_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TRIM  = 2'd2,
    CMD_CLEAR = 2'd3
  } thr_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TRIM = 1'b1
  } thr_state_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    thr_cmd_t    cmd;
    logic [31:0] now_ms;
    logic [7:0]  entry_value;
    logic [3:0]  entry_number;
  } thr_in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  slot_index;
    logic [31:0] entry_age;
    logic [7:0]  read_value;
    logic [4:0]  live_count;
  } thr_out_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  value;
  } thr_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic        shift_en;
    logic [31:0] now_ms;
    logic [31:0] max_age;
    logic [3:0]  rd_num;
  } thr_cell_ctl_t;

endpackage

### sv/thr_cell.sv
// one entry of the history ring: stamp and value, age check, read select
// depends on thr_pkg
module thr_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                   clk,
  input  thr_pkg::thr_cell_ctl_t ctl,
  input  logic [CW-1:0]          count,
  input  thr_pkg::thr_entry_t    ent_in,
  output thr_pkg::thr_entry_t    ent_out,
  output logic [31:0]            sel_age,
  output logic [7:0]             sel_value,
  output logic                   drop_req
);

  thr_pkg::thr_entry_t ent_r;
  logic [31:0]         age;
  logic                match;
  logic                oldest;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      ent_r <= ent_in;
    end
  end

  assign ent_out = ent_r;
  assign age     = ctl.now_ms - ent_r.stamp;
  assign match   = (32'(ctl.rd_num) == 32'(IDX));
  // this cell holds the oldest live word
  assign oldest  = (count == CW'(IDX + 1));

  assign sel_age   = match ? age : 32'd0;
  assign sel_value = match ? ent_r.value : 8'd0;
  assign drop_req  = oldest && (age >= ctl.max_age);

endmodule

### sv/timestamped_history_ring.sv
// timestamped history ring, top level: control, count, pointer, output register
// depends on thr_pkg, thr_cell and timestamped_history_ring_defines.svh
//
//  port group   dir  handshake              word
//  in_          in   start & !busy          thr_pkg::thr_in_t
//  out_         out  out_valid strobe       thr_pkg::thr_out_t
//  cfg_         in   cfg_we                 32 bit max age
//
// add, read and clear give their result strobe in the cycle after they are accepted.
// trim holds busy and drops one word per cycle at the oldest cell; its result
// strobes once no cell asks for a drop any more.
// rst_n is synchronous: count, pointer, state and max age return to reset;
// the cell contents are not cleared. the receiver takes every strobe, no stall.
`include "timestamped_history_ring_defines.svh"

module timestamped_history_ring #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  thr_pkg::thr_in_t  in_word,
  output logic              out_valid,
  output thr_pkg::thr_out_t out_word,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  thr_pkg::thr_state_t   state_r, state_nxt;
  logic [SW-1:0]         newest_r, newest_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [31:0]           now_r, now_nxt;
  logic [31:0]           max_age_r;
  logic                  out_valid_r, out_valid_nxt;
  thr_pkg::thr_out_t     out_word_r, out_nxt;

  thr_pkg::thr_cell_ctl_t ctl;
  thr_pkg::thr_entry_t    chain [DEPTH+1];
  logic [31:0]            cell_age [DEPTH];
  logic [7:0]             cell_value [DEPTH];
  logic [DEPTH-1:0]       cell_drop;
  logic [31:0]            rd_age;
  logic [7:0]             rd_value;
  logic                   drop_any;
  logic                   accept;
  logic                   found;
  logic [SW:0]            slot_sum;
  logic [SW-1:0]          rd_slot;

  assign accept = start && (state_r == thr_pkg::ST_IDLE);
  assign busy   = (state_r == thr_pkg::ST_TRIM);

  assign ctl.shift_en = accept && (in_word.cmd == thr_pkg::CMD_ADD);
  assign ctl.now_ms   = (state_r == thr_pkg::ST_TRIM) ? now_r : in_word.now_ms;
  assign ctl.max_age  = max_age_r;
  assign ctl.rd_num   = in_word.entry_number;

  assign chain[0].stamp = in_word.now_ms;
  assign chain[0].value = in_word.entry_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    thr_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .ent_in    (chain[i]),
      .ent_out   (chain[i+1]),
      .sel_age   (cell_age[i]),
      .sel_value (cell_value[i]),
      .drop_req  (cell_drop[i])
    );
  end

  // at most one cell matches the read number
  always_comb begin
    rd_age   = 32'd0;
    rd_value = 8'd0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_age   = rd_age | cell_age[i];
      rd_value = rd_value | cell_value[i];
    end
  end

  assign drop_any = |cell_drop;
  assign found    = (32'(in_word.entry_number) < 32'(count_r));
  assign slot_sum = {1'b0, newest_r} + (SW+1)'(in_word.entry_number);
  assign rd_slot  = (slot_sum >= (SW+1)'(DEPTH)) ? SW'(slot_sum - (SW+1)'(DEPTH))
                                                 : SW'(slot_sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      thr_pkg::ST_IDLE: begin
        if (accept && (in_word.cmd == thr_pkg::CMD_TRIM)) begin
          state_nxt = thr_pkg::ST_TRIM;
        end
      end
      thr_pkg::ST_TRIM: begin
        if (!drop_any) begin
          state_nxt = thr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = thr_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    newest_nxt    = newest_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    case (state_r)
      thr_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_word.cmd)
            thr_pkg::CMD_ADD: begin
              newest_nxt = (newest_r == '0) ? SW'(DEPTH - 1) : newest_r - 1'b1;
              if (count_r < CW'(DEPTH)) begin
                count_nxt = count_r + 1'b1;
              end
              out_valid_nxt      = 1'b1;
              out_nxt.slot_index = 4'(newest_nxt);
              out_nxt.live_count = 5'(count_nxt);
            end
            thr_pkg::CMD_READ: begin
              out_valid_nxt      = 1'b1;
              out_nxt.live_count = 5'(count_r);
              if (found) begin
                out_nxt.status     = thr_pkg::STATUS_OK;
                out_nxt.slot_index = 4'(rd_slot);
                out_nxt.entry_age  = rd_age;
                out_nxt.read_value = rd_value;
              end else begin
                out_nxt.status = thr_pkg::STATUS_NOT_FOUND;
              end
            end
            thr_pkg::CMD_TRIM: begin
              now_nxt = in_word.now_ms;
            end
            thr_pkg::CMD_CLEAR: begin
              newest_nxt    = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      thr_pkg::ST_TRIM: begin
        if (drop_any) begin
          count_nxt = count_r - 1'b1;
        end else begin
          out_valid_nxt      = 1'b1;
          out_nxt.live_count = 5'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= thr_pkg::ST_IDLE;
      newest_r    <= '0;
      count_r     <= '0;
      max_age_r   <= 32'h7FFF_FFFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (out_valid_nxt) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `THR_ASSERT_NEXT(a_quick_cmd_result, accept && (in_word.cmd != thr_pkg::CMD_TRIM), out_valid, "add, read or clear gave no result")
  `THR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "live count beyond depth")
  `THR_ASSERT_NEXT(a_trim_done, busy && !drop_any, out_valid && !busy, "trim ended without a result")
  `THR_ASSERT_NOW(a_miss_zero, out_valid && out_word.status, (out_word.slot_index == 4'd0) && (out_word.entry_age == 32'd0), "not-found result carries data")

endmodule
